@@ sv/soft_timer_event_table_macros.svh @@
// Assertion macros for the soft timer event table.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef SOFT_TIMER_EVENT_TABLE_MACROS_SVH
`define SOFT_TIMER_EVENT_TABLE_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define STE_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define STE_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define STE_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/ste_pkg.sv @@
// Types and constants for the soft timer event table.
// No dependencies.
package ste_pkg;

  localparam int unsigned DW          = 32;
  localparam int unsigned TW          = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RW          = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CFG_AW      = 8;

  // Commands
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_RESTART = 3'd3;
  localparam logic [2:0] CMD_DISP    = 3'd4;

  // Modes
  localparam logic [1:0] MODE_PERIODIC = 2'd1;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
  localparam logic [2:0] ST_NULL_TAG    = 3'd2;
  localparam logic [2:0] ST_BAD_PERIOD  = 3'd3;
  localparam logic [2:0] ST_BAD_MODE    = 3'd4;
  localparam logic [2:0] ST_FULL        = 3'd5;
  localparam logic [2:0] ST_UNKNOWN_TAG = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ENABLED       = 8'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_PERIOD    = 8'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_PERIOD    = 8'd2;
  localparam logic [CFG_AW-1:0] REG_COUNTER_LIMIT = 8'd3;

  typedef struct packed {
    logic [DW-1:0] period;
    logic [TW-1:0] tag;
    logic          periodic;
    logic          ready;
    logic          stopped;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EX, S_DIV, S_MRD, S_MEX, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    OP_TICK, OP_MARK, OP_DISP, OP_FIX
  } op_e;

endpackage

@@ sv/ste_if.sv @@
// Handshake channels of the soft timer event table: command, result, config.
// Depends on ste_pkg.
interface ste_cmd_if;
  import ste_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    command;
  logic [TW-1:0] event_tag;
  logic [DW-1:0] period;
  logic [1:0]    mode;
  modport source (output valid, command, event_tag, period, mode, input ready);
  modport sink (input valid, command, event_tag, period, mode, output ready);
endinterface

interface ste_res_if;
  import ste_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic          fired_valid;
  logic [TW-1:0] fired_tag;
  logic          last;
  modport source (output valid, status, fired_valid, fired_tag, last, input ready);
  modport sink (input valid, status, fired_valid, fired_tag, last, output ready);
endinterface

interface ste_cfg_if;
  import ste_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [DW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ste_mem.sv @@
// Entry memory: one write port, one read port, registered read data.
// Depends on ste_pkg.
module ste_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  ste_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [IW-1:0]   raddr_i,
  output ste_pkg::entry_t rdata_o
);
  import ste_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ste_mod.sv @@
// Serial remainder unit: one quotient bit per cycle, reports a zero remainder.
// Depends on ste_pkg.
module ste_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ste_pkg::DW-1:0] dividend_i,
  input  logic [ste_pkg::DW-1:0] divisor_i,
  output logic                 done_o,
  output logic                 zero_o
);
  import ste_pkg::*;

  localparam int unsigned NW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  // One restoring step
  always_comb begin
    shifted = {rem_q, dvd_q[DW-1]};
    diff    = shifted - {1'b0, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    div_d   = div_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = NW'(DW);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (shifted >= {1'b0, div_q}) ? diff[DW-1:0] : shifted[DW-1:0];
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

@@ sv/soft_timer_event_table.sv @@
// Soft timer event table. Commands arrive on cmd_i; results leave on res_o.
// Configuration writes on cfg_i are always taken (ready is tied high) and
// must only be issued while the block is idle.
// Each command gives one result, except dispatch, which gives one result per
// emitted tag (up to sixteen), with last set on the final one.
// Add, unknown commands and rejected commands finish without a scan. Stop and
// restart read every filled entry and write back those carrying the tag.
// Tick reads and compares each entry and runs the serial remainder unit on
// each live one (not stopped, nonzero period). Dispatch reads each entry
// and, for each one-shot entry fired while enabled, makes a second pass over
// every entry to stop every entry carrying that tag.
// cmd_i is ready only between commands. The result register lets the final
// result wait while the next command is taken. When res_o stalls, the
// sequencer holds until the result register is free.
// Reset clears the counter and the fill count and sets the configuration to
// defaults; entries are never read before written, so no clearing pass runs.
// Depends on ste_pkg, ste_if, ste_mem, ste_mod and the assertion macros.
`include "soft_timer_event_table_macros.svh"

module soft_timer_event_table #(
  parameter int unsigned MAX_EVENTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ste_cmd_if.sink  cmd_i,
  ste_res_if.source res_o,
  ste_cfg_if.sink  cfg_i
);
  import ste_pkg::*;

  localparam int unsigned IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  logic          enabled_q;
  logic [DW-1:0] min_q, max_q, limit_q;
  logic [DW-1:0] tick_q, tick_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] sub_q, sub_d;
  logic [RW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] tag_q, tag_d;
  logic          stop_q, stop_d;
  logic          hit_q, hit_d;
  logic [2:0]    status_q, status_d;
  logic          pend_q, pend_d;
  logic [TW-1:0] pend_tag_q, pend_tag_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q, out_status_d;
  logic          out_fv_q, out_fv_d;
  logic [TW-1:0] out_tag_q, out_tag_d;
  logic          out_last_q, out_last_d;
  logic          out_load, out_free;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, ent;
  logic          mod_start, mod_done, mod_zero;

  logic          in_fire;
  logic          scan_end, run_div, oneshot_stop, fired;

  assign in_fire  = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign scan_end = (idx_q >= used_q) ||
                    ((op_q == OP_DISP) && (cnt_q == RW'(MAX_RESULTS)));
  assign run_div  = !ent.stopped && (ent.period != '0);
  assign fired    = ent.ready && (!pend_q || out_free);
  assign oneshot_stop = !ent.periodic && enabled_q;

  ste_mem #(.DEPTH(MAX_EVENTS), .IW(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (ent)
  );

  ste_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tick_q),
    .divisor_i  (ent.period),
    .done_o     (mod_done),
    .zero_o     (mod_zero)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_i.command)
            CMD_TICK, CMD_DISP: state_d = S_RD;
            CMD_STOP, CMD_RESTART: begin
              state_d = (enabled_q && cmd_i.event_tag != '0) ? S_RD : S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_RD: state_d = scan_end ? S_FIN : S_EX;
      S_EX: begin
        case (op_q)
          OP_TICK: state_d = run_div ? S_DIV : S_RD;
          OP_DISP: begin
            if (ent.ready) begin
              if (!fired) state_d = S_EX;
              else state_d = oneshot_stop ? S_MRD : S_RD;
            end else begin
              state_d = S_RD;
            end
          end
          default: state_d = S_RD;
        endcase
      end
      S_DIV: state_d = mod_done ? S_RD : S_DIV;
      S_MRD: state_d = (sub_q >= used_q) ? S_RD : S_MEX;
      S_MEX: state_d = S_MRD;
      S_FIN: state_d = out_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d = op_q; tick_d = tick_q; used_d = used_q; idx_d = idx_q; sub_d = sub_q;
    cnt_d = cnt_q; tag_d = tag_q; stop_d = stop_q; hit_d = hit_q;
    status_d = status_q; pend_d = pend_q; pend_tag_d = pend_tag_q;
    mem_we = 1'b0; mem_waddr = idx_q[IW-1:0]; mem_wdata = ent;
    mem_re = 1'b0; mem_raddr = idx_q[IW-1:0];
    mod_start = 1'b0;
    out_load = 1'b0; out_status_d = out_status_q; out_fv_d = out_fv_q;
    out_tag_d = out_tag_q; out_last_d = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          idx_d = '0;
          status_d = ST_OK;
          op_d = OP_FIX;
          case (cmd_i.command)
            CMD_TICK: begin
              op_d = OP_TICK;
              tick_d = (tick_q < limit_q) ? tick_q + DW'(1) : DW'(1);
            end
            CMD_ADD: begin
              if (!enabled_q) status_d = ST_NOT_ENABLED;
              else if (cmd_i.event_tag == '0) status_d = ST_NULL_TAG;
              else if (cmd_i.period < min_q || cmd_i.period > max_q)
                status_d = ST_BAD_PERIOD;
              else if (cmd_i.mode > MODE_PERIODIC) status_d = ST_BAD_MODE;
              else if (used_q >= CW'(MAX_EVENTS)) status_d = ST_FULL;
              else begin
                mem_we = 1'b1;
                mem_waddr = used_q[IW-1:0];
                mem_wdata.period = cmd_i.period;
                mem_wdata.tag = cmd_i.event_tag;
                mem_wdata.periodic = (cmd_i.mode == MODE_PERIODIC);
                mem_wdata.ready = 1'b0;
                mem_wdata.stopped = 1'b0;
                used_d = used_q + CW'(1);
              end
            end
            CMD_STOP, CMD_RESTART: begin
              tag_d = cmd_i.event_tag;
              stop_d = (cmd_i.command == CMD_STOP);
              hit_d = 1'b0;
              if (!enabled_q) status_d = ST_NOT_ENABLED;
              else if (cmd_i.event_tag == '0) status_d = ST_NULL_TAG;
              else op_d = OP_MARK;
            end
            CMD_DISP: begin
              op_d = OP_DISP;
              pend_d = 1'b0;
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        mem_re = !scan_end;
      end
      S_EX: begin
        case (op_q)
          OP_TICK: begin
            mod_start = run_div;
            if (!run_div) idx_d = idx_q + CW'(1);
          end
          OP_MARK: begin
            if (ent.tag == tag_q) begin
              mem_we = 1'b1;
              mem_wdata.stopped = stop_q;
              hit_d = 1'b1;
            end
            idx_d = idx_q + CW'(1);
          end
          OP_DISP: begin
            if (!ent.ready) begin
              idx_d = idx_q + CW'(1);
            end else if (fired) begin
              // push the previous tag out, keep this one pending
              if (pend_q) begin
                out_load = 1'b1;
                out_status_d = ST_OK;
                out_fv_d = 1'b1;
                out_tag_d = pend_tag_q;
                out_last_d = 1'b0;
              end
              pend_d = 1'b1;
              pend_tag_d = ent.tag;
              cnt_d = cnt_q + RW'(1);
              mem_we = 1'b1;
              mem_wdata.ready = 1'b0;
              tag_d = ent.tag;
              sub_d = '0;
              if (!oneshot_stop) idx_d = idx_q + CW'(1);
            end
          end
          default: idx_d = idx_q + CW'(1);
        endcase
      end
      S_DIV: begin
        if (mod_done) begin
          idx_d = idx_q + CW'(1);
          if (mod_zero) begin
            mem_we = 1'b1;
            mem_wdata.ready = 1'b1;
          end
        end
      end
      S_MRD: begin
        if (sub_q >= used_q) begin
          idx_d = idx_q + CW'(1);
        end else begin
          mem_re = 1'b1;
          mem_raddr = sub_q[IW-1:0];
        end
      end
      S_MEX: begin
        mem_waddr = sub_q[IW-1:0];
        if (ent.tag == tag_q) begin
          mem_we = 1'b1;
          mem_wdata.stopped = 1'b1;
        end
        sub_d = sub_q + CW'(1);
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last_d = 1'b1;
          out_fv_d = 1'b0;
          out_tag_d = '0;
          out_status_d = status_q;
          if (op_q == OP_MARK) begin
            out_status_d = hit_q ? ST_OK : ST_UNKNOWN_TAG;
          end else if (op_q == OP_DISP && pend_q) begin
            out_fv_d = 1'b1;
            out_tag_d = pend_tag_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register valid
  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_FIX;
      tick_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      enabled_q   <= 1'b0;
      min_q       <= DW'(1);
      max_q       <= '1;
      limit_q     <= '1;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      tick_q      <= tick_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      // config write; unknown indexes are dropped
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_ENABLED:       enabled_q <= cfg_i.data[0];
          REG_MIN_PERIOD:    min_q <= cfg_i.data;
          REG_MAX_PERIOD:    max_q <= cfg_i.data;
          REG_COUNTER_LIMIT: limit_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    sub_q        <= sub_d;
    cnt_q        <= cnt_d;
    tag_q        <= tag_d;
    stop_q       <= stop_d;
    hit_q        <= hit_d;
    status_q     <= status_d;
    pend_q       <= pend_d;
    pend_tag_q   <= pend_tag_d;
    out_status_q <= out_status_d;
    out_fv_q     <= out_fv_d;
    out_tag_q    <= out_tag_d;
    out_last_q   <= out_last_d;
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.fired_valid = out_fv_q;
  assign res_o.fired_tag   = out_tag_q;
  assign res_o.last        = out_last_q;

  `STE_ASSERT(a_used_bound, used_q <= CW'(MAX_EVENTS), "fill count beyond table size")
  `STE_ASSERT_IMP(a_fired_ok, out_valid_q && out_fv_q, out_status_q == ST_OK, "bad fired status")
  `STE_ASSERT_IMP(a_div_start, mod_start, state_q == S_EX && op_q == OP_TICK, "stray start")
  `STE_ASSERT_NXT(a_div_wait, mod_start, state_q == S_DIV, "remainder not awaited")
  `STE_ASSERT_IMP(a_wr_filled, mem_we && state_q != S_IDLE, CW'(mem_waddr) < used_q, "bad write")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the soft timer event table: directed table, then random
// phases under several register settings, checked against an in-bench model and typed statuses.
// Depends on ste_pkg, ste_if and the soft_timer_event_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ste_pkg::*;

  localparam int unsigned     N_EVENTS   = 16;
  localparam int unsigned     RAND_ITEMS = 360;
  localparam logic [CFG_AW-1:0] REG_SPARE = 8'd4;  // past the register list
  localparam logic [2:0]      CMD_BOGUS  = 3'd5;
  localparam logic [2:0]      CMD_TOP    = 3'd7;
  localparam logic [1:0]      MODE_ONESHOT = 2'd0;
  localparam logic [1:0]      MODE_BAD2    = 2'd2;
  localparam logic [1:0]      MODE_BAD3    = 2'd3;

  typedef struct {
    logic [2:0]    cmd;
    logic [TW-1:0] tag;
    logic [DW-1:0] period;
    logic [1:0]    mode;
  } timer_cmd_t;

  typedef struct {
    logic [2:0]    status;
    logic          fired;
    logic [TW-1:0] tag;
    logic          last;
  } fire_rec_t;

  typedef struct {
    timer_cmd_t c;
    bit         typed;
    logic [2:0] status;
  } script_row_t;

  logic clk;
  logic rst_n;

  ste_cmd_if cmd_bus();
  ste_res_if res_bus();
  ste_cfg_if cfg_bus();

  soft_timer_event_table #(.MAX_EVENTS(N_EVENTS)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  // Mirror of the table, the counter and the registers
  logic          en_r;
  logic [DW-1:0] min_per_r, max_per_r, wrap_r;
  logic [DW-1:0] tick_cnt;
  int unsigned   filled;
  logic [DW-1:0] ev_period [N_EVENTS];
  logic [TW-1:0] ev_tag    [N_EVENTS];
  logic          ev_repeat [N_EVENTS];
  logic          ev_due    [N_EVENTS];
  logic          ev_halted [N_EVENTS];

  fire_rec_t pending_fires[$];
  int unsigned err_count, n_items, n_results, n_fired, n_full;
  bit quiet;  // no idling on either side while set

  task automatic report(input string what);
    err_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic logic [2:0] mark_events(input logic [TW-1:0] tag, input logic halt);
    bit hit;
    hit = 0;
    if (!en_r) return ST_NOT_ENABLED;
    if (tag == '0) return ST_NULL_TAG;
    for (int i = 0; i < filled; i++) begin
      if (ev_tag[i] == tag) begin
        ev_halted[i] = halt;
        hit = 1;
      end
    end
    return hit ? ST_OK : ST_UNKNOWN_TAG;
  endfunction

  // Update the mirror for one accepted command and queue the results it causes
  function automatic void predict_fires(input timer_cmd_t c);
    logic [2:0] st;
    int k;
    st = ST_OK;
    k = 0;
    case (c.cmd)
      CMD_TICK: begin
        tick_cnt = (tick_cnt < wrap_r) ? tick_cnt + 1 : 32'd1;
        for (int i = 0; i < filled; i++)
          if (!ev_halted[i] && ev_period[i] != 0 && (tick_cnt % ev_period[i]) == 0)
            ev_due[i] = 1;
      end
      CMD_ADD: begin
        if (!en_r) st = ST_NOT_ENABLED;
        else if (c.tag == '0) st = ST_NULL_TAG;
        else if (c.period < min_per_r || c.period > max_per_r) st = ST_BAD_PERIOD;
        else if (c.mode > MODE_PERIODIC) st = ST_BAD_MODE;
        else if (filled >= N_EVENTS) st = ST_FULL;
        else begin
          ev_period[filled] = c.period;
          ev_tag[filled]    = c.tag;
          ev_repeat[filled] = (c.mode == MODE_PERIODIC);
          ev_due[filled]    = 0;
          ev_halted[filled] = 0;
          filled++;
        end
      end
      CMD_STOP:    st = mark_events(c.tag, 1'b1);
      CMD_RESTART: st = mark_events(c.tag, 1'b0);
      CMD_DISP: begin
        for (int i = 0; i < filled && k < MAX_RESULTS; i++) begin
          if (ev_due[i]) begin
            pending_fires.push_back('{ST_OK, 1'b1, ev_tag[i], 1'b0});
            k++;
            ev_due[i] = 0;
            if (!ev_repeat[i]) void'(mark_events(ev_tag[i], 1'b1));
          end
        end
        if (k > 0) begin
          pending_fires[$].last = 1'b1;
          return;
        end
      end
      default: ;
    endcase
    pending_fires.push_back('{st, 1'b0, '0, 1'b1});
  endfunction

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Result side: random stall, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    fire_rec_t want;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= quiet || ($urandom_range(99) >= 18);
      if (res_bus.valid && res_bus.ready) begin
        n_results++;
        if (res_bus.fired_valid) n_fired++;
        if (res_bus.status == ST_FULL) n_full++;
        if (pending_fires.size() == 0) begin
          report($sformatf("unexpected result status=%0d tag=%h",
                           res_bus.status, res_bus.fired_tag));
        end else begin
          want = pending_fires.pop_front();
          if (res_bus.status !== want.status)
            report($sformatf("status %0d, want %0d", res_bus.status, want.status));
          if (res_bus.fired_valid !== want.fired)
            report($sformatf("fired_valid %b, want %b", res_bus.fired_valid, want.fired));
          if (res_bus.fired_tag !== want.tag)
            report($sformatf("fired_tag %h, want %h", res_bus.fired_tag, want.tag));
          if (res_bus.last !== want.last)
            report($sformatf("last %b, want %b", res_bus.last, want.last));
        end
      end
    end
  end

  // Command transfer with random gaps ahead of it; valid stays high between items unless a gap drops it
  task automatic send_cmd(input timer_cmd_t c);
    while (!quiet && $urandom_range(99) < 18) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.command   <= c.cmd;
    cmd_bus.event_tag <= c.tag;
    cmd_bus.period    <= c.period;
    cmd_bus.mode      <= c.mode;
    do @(posedge clk); while (!cmd_bus.ready);
    n_items++;
    predict_fires(c);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic drain;
    cmd_bus.valid <= 1'b0;
    wait (pending_fires.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [DW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_ENABLED:       en_r      = val[0];
      REG_MIN_PERIOD:    min_per_r = val;
      REG_MAX_PERIOD:    max_per_r = val;
      REG_COUNTER_LIMIT: wrap_r    = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic en, input logic [DW-1:0] lo, input logic [DW-1:0] hi,
                          input logic [DW-1:0] wrap);
    write_reg(REG_ENABLED, {31'd0, en});
    write_reg(REG_MIN_PERIOD, lo);
    write_reg(REG_MAX_PERIOD, hi);
    write_reg(REG_COUNTER_LIMIT, wrap);
  endtask

  // Mostly small tags and periods so stops, restarts and firings line up
  function automatic timer_cmd_t rand_cmd;
    timer_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 44)      c.cmd = CMD_TICK;
    else if (pick < 64) c.cmd = CMD_ADD;
    else if (pick < 74) c.cmd = CMD_STOP;
    else if (pick < 84) c.cmd = CMD_RESTART;
    else if (pick < 98) c.cmd = CMD_DISP;
    else                c.cmd = 3'($urandom_range(CMD_TOP, CMD_BOGUS));
    pick = $urandom_range(99);
    if (pick < 3)       c.tag = '0;
    else if (pick < 13) c.tag = TW'($urandom);
    else                c.tag = TW'($urandom_range(6, 1));
    pick = $urandom_range(99);
    c.period = (pick < 10) ? $urandom : DW'($urandom_range(7, 1));
    c.mode = ($urandom_range(99) < 10) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
    return c;
  endfunction

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();  // sender holds off until the block has caught up
      end
      send_cmd(rand_cmd());
    end
    drain();
  endtask

  script_row_t script_rows[] = '{
    '{'{CMD_ADD,     16'h0001, 32'd1,       MODE_ONESHOT},  1, ST_NOT_ENABLED},
    '{'{CMD_STOP,    16'h0001, 32'd0,       MODE_ONESHOT},  1, ST_NOT_ENABLED},
    '{'{CMD_RESTART, 16'h0000, 32'd0,       MODE_ONESHOT},  1, ST_NOT_ENABLED},
    '{'{CMD_TICK,    16'h0000, 32'd0,       MODE_ONESHOT},  1, ST_OK},
    '{'{CMD_DISP,    16'h0000, 32'd0,       MODE_ONESHOT},  1, ST_OK},
    // registers enabled from here on
    '{'{CMD_ADD,     16'h0000, 32'd4,       MODE_PERIODIC}, 1, ST_NULL_TAG},
    '{'{CMD_ADD,     16'h0003, 32'd0,       MODE_PERIODIC}, 1, ST_BAD_PERIOD},
    '{'{CMD_ADD,     16'h0003, 32'd5,       MODE_BAD2},     1, ST_BAD_MODE},
    '{'{CMD_ADD,     16'h0003, 32'd5,       MODE_BAD3},     1, ST_BAD_MODE},
    '{'{CMD_STOP,    16'h0009, 32'd0,       MODE_ONESHOT},  1, ST_UNKNOWN_TAG},
    '{'{CMD_RESTART, 16'h0000, 32'd0,       MODE_ONESHOT},  1, ST_NULL_TAG},
    '{'{CMD_BOGUS,   16'hFFFF, 32'hFFFFFFFF, MODE_BAD3},    1, ST_OK},
    '{'{CMD_TOP,     16'h0000, 32'd0,       MODE_ONESHOT},  1, ST_OK},
    '{'{CMD_ADD,     16'hFFFF, 32'hFFFFFFFF, MODE_PERIODIC}, 1, ST_OK},
    '{'{CMD_ADD,     16'h0001, 32'd1,       MODE_ONESHOT},  1, ST_OK},
    '{'{CMD_ADD,     16'h0001, 32'd2,       MODE_PERIODIC}, 1, ST_OK},
    '{'{CMD_ADD,     16'h0002, 32'd3,       MODE_PERIODIC}, 1, ST_OK},
    '{'{CMD_TICK,    16'h0000, 32'd0,       MODE_ONESHOT},  0, ST_OK},
    '{'{CMD_DISP,    16'h0000, 32'd0,       MODE_ONESHOT},  0, ST_OK},
    '{'{CMD_TICK,    16'h0000, 32'd0,       MODE_ONESHOT},  0, ST_OK},
    '{'{CMD_DISP,    16'h0000, 32'd0,       MODE_ONESHOT},  0, ST_OK},
    '{'{CMD_STOP,    16'h0002, 32'd0,       MODE_ONESHOT},  1, ST_OK},
    '{'{CMD_TICK,    16'h0000, 32'd0,       MODE_ONESHOT},  0, ST_OK},
    '{'{CMD_RESTART, 16'h0001, 32'd0,       MODE_ONESHOT},  1, ST_OK},
    '{'{CMD_DISP,    16'h0000, 32'd0,       MODE_ONESHOT},  0, ST_OK}
  };

  // Stimulus
  initial begin
    int unsigned tail;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_TICK;
    cmd_bus.event_tag = '0;
    cmd_bus.period = '0;
    cmd_bus.mode = MODE_ONESHOT;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_ENABLED;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;
    rst_n = 1'b0;
    quiet = 1'b0;
    en_r = 1'b0;
    min_per_r = 32'd1;
    max_per_r = 32'hFFFFFFFF;
    wrap_r = 32'hFFFFFFFF;
    tick_cnt = '0;
    filled = 0;
    err_count = 0;
    n_items = 0;
    n_results = 0;
    n_fired = 0;
    n_full = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows stand in for the model's own expectation
    foreach (script_rows[r]) begin
      if (r == 5) begin
        drain();
        write_reg(REG_ENABLED, 32'd1);
      end
      send_cmd(script_rows[r].c);
      if (script_rows[r].typed) begin
        void'(pending_fires.pop_back());
        pending_fires.push_back('{script_rows[r].status, 1'b0, '0, 1'b1});
      end
    end
    drain();

    // Random phases under different register settings
    set_regs(1'b1, 32'd1, 32'hFFFFFFFF, 32'd12);
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    run_random(110);
    set_regs(1'b1, 32'd2, 32'd5, 32'd1);
    quiet = 1'b1;
    run_random(80);
    quiet = 1'b0;
    set_regs(1'b0, 32'd1, 32'd8, 32'hFFFFFFFF);
    run_random(50);
    set_regs(1'b1, 32'd1, 32'hFFFFFFFF, 32'd60);
    run_random(RAND_ITEMS - 240);

    tail = 0;
    while (pending_fires.size() != 0 && tail < 100000) begin
      @(posedge clk);
      tail++;
    end
    repeat (50) @(posedge clk);
    if (pending_fires.size() != 0) report("results still expected at end of run");

    $display("Ran %0d commands, checked %0d results (%0d fired tags, %0d table-full).",
             n_items, n_results, n_fired, n_full);
    $display("Covered all commands, every status code and four register settings.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #25ms;
    $display("Timeout waiting on the block");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
